>>> rtl/ffra_pkg.sv
// shared types and constants of the first-fit range allocator
// used by ffra_ctrl, ffra_dpath and first_fit_range_allocator_top
`default_nettype none
package ffra_pkg;

   localparam int ADDR_W         = 12;
   localparam int LEN_W          = 13;
   localparam int STATUS_W       = 2;
   localparam int HEAP_BYTES_DEF = 4096;
   localparam int MAX_RANGES_DEF = 16;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_NOFIT = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic              kind;
      logic [LEN_W-1:0]  request_bytes;
      logic [ADDR_W-1:0] block_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   granted_address;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // datapath operations issued by the controller, one per cycle
   typedef enum logic [3:0] {
      DP_NOP,
      DP_INIT,
      DP_CAPTURE,
      DP_SCAN_NEXT,
      DP_ALLOC_TAKE,
      DP_REMOVE_STEP,
      DP_REMOVE_END,
      DP_FREE_STEP,
      DP_MERGE_BOTH,
      DP_MERGE_PREV,
      DP_MERGE_NEXT,
      DP_INSERT_BEGIN,
      DP_INSERT_STEP,
      DP_INSERT_PUT,
      DP_RESPOND
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      status_type rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic req_zero;
      logic at_end;
      logic fit;
      logic exact;
      logic rm_last;
      logic free_bad;
      logic scan_more;
      logic overlap;
      logic merge_prev;
      logic merge_next;
      logic full;
      logic ins_done;
   } dp_flags_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC_SCAN,
      S_FREE_SIZE,
      S_FREE_SCAN,
      S_REMOVE,
      S_INSERT,
      S_DONE
   } ctrl_state_type;

endpackage
`default_nettype wire

>>> rtl/ffra_ctrl.sv
// controller state machine of the range allocator
// depends on ffra_pkg; drives ffra_dpath by commands, reads its flags
`default_nettype none
module ffra_ctrl
   import ffra_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic         req_kind,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   output logic              busy,
   input  wire dp_flags_type flags,
   output dp_cmd_type        cmd
);

   ctrl_state_type state_ff, state_in;
   status_type     code_ff, code_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      code_in        = code_ff;
      cmd.op         = DP_NOP;
      cmd.rsp_status = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = DP_CAPTURE;
               code_in  = ST_OK;
               state_in = req_kind ? S_FREE_SIZE : S_ALLOC_SCAN;
            end else if (csr_valid) begin
               cmd.op = DP_INIT;
            end
         end
         S_ALLOC_SCAN: begin
            if (flags.req_zero || flags.at_end) begin
               code_in  = ST_NOFIT;
               state_in = S_DONE;
            end else if (flags.fit) begin
               cmd.op   = DP_ALLOC_TAKE;
               code_in  = ST_OK;
               state_in = flags.exact ? S_REMOVE : S_DONE;
            end else begin
               cmd.op = DP_SCAN_NEXT;
            end
         end
         S_REMOVE: begin
            if (flags.rm_last) begin
               cmd.op   = DP_REMOVE_END;
               state_in = S_DONE;
            end else begin
               cmd.op = DP_REMOVE_STEP;
            end
         end
         S_FREE_SIZE: begin
            state_in = flags.free_bad ? S_DONE : S_FREE_SCAN;
         end
         S_FREE_SCAN: begin
            if (flags.scan_more) begin
               cmd.op = DP_FREE_STEP;
            end else if (flags.overlap) begin
               state_in = S_DONE;
            end else if (flags.merge_prev && flags.merge_next) begin
               cmd.op   = DP_MERGE_BOTH;
               state_in = S_REMOVE;
            end else if (flags.merge_prev) begin
               cmd.op   = DP_MERGE_PREV;
               state_in = S_DONE;
            end else if (flags.merge_next) begin
               cmd.op   = DP_MERGE_NEXT;
               state_in = S_DONE;
            end else if (flags.full) begin
               code_in  = ST_FULL;
               state_in = S_DONE;
            end else begin
               cmd.op   = DP_INSERT_BEGIN;
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            if (flags.ins_done) begin
               cmd.op   = DP_INSERT_PUT;
               state_in = S_DONE;
            end else begin
               cmd.op = DP_INSERT_STEP;
            end
         end
         S_DONE: begin
            cmd.op   = DP_RESPOND;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/ffra_dpath.sv
// datapath: free range table, granted size memory, scan pointers, result register
// depends on ffra_pkg; commanded by ffra_ctrl
`default_nettype none
module ffra_dpath
   import ffra_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire dp_cmd_type cmd,
   input  wire req_type    req_data,
   input  wire logic [LEN_W-1:0] csr_data,
   output dp_flags_type    flags,
   output logic            rsp_valid,
   output rsp_type         rsp_data
);

   localparam int HEAP_BYTES = HEAP_BYTES_DEF;
   localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int HW = $clog2(HEAP_BYTES);
   localparam int EW = ADDR_W + 2;

   logic [ADDR_W-1:0] start_ff [MAX_RANGES];
   logic [LEN_W-1:0]  len_ff   [MAX_RANGES];
   logic [CW-1:0]     cnt_ff, idx_ff, sh_ff;
   req_type           req_ff;
   logic [EW-1:0]     prev_end_ff;
   logic [LEN_W-1:0]  prev_len_ff;
   logic              has_prev_ff;
   logic [ADDR_W-1:0] grant_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   logic [LEN_W-1:0]  gmem [HEAP_BYTES];
   logic [LEN_W-1:0]  size_ff;

   logic [CW-1:0]     idx_p1, sh_m1;
   logic [IW-1:0]     rd_idx;
   logic [ADDR_W-1:0] cur_start, nxt_start, below_start;
   logic [LEN_W-1:0]  cur_len, nxt_len, below_len;
   logic [EW-1:0]     free_end, cur_start_w, addr_w;
   logic              has_next, in_heap;
   logic [31:0]       init_len;

   // table reads: at the scan pointer, the entry after it, the entry below the shift pointer
   assign idx_p1      = idx_ff + CW'(1);
   assign sh_m1       = sh_ff - CW'(1);
   assign rd_idx      = idx_ff[IW-1:0];
   assign cur_start   = start_ff[rd_idx];
   assign cur_len     = len_ff[rd_idx];
   assign nxt_start   = start_ff[idx_p1[IW-1:0]];
   assign nxt_len     = len_ff[idx_p1[IW-1:0]];
   assign below_start = start_ff[sh_m1[IW-1:0]];
   assign below_len   = len_ff[sh_m1[IW-1:0]];

   // status toward the controller
   assign addr_w      = EW'(req_ff.block_address);
   assign cur_start_w = EW'(cur_start);
   assign free_end    = addr_w + EW'(size_ff);
   assign has_next    = (idx_ff < cnt_ff);
   assign in_heap     = (32'(req_ff.block_address) < 32'(HEAP_BYTES));

   always_comb begin
      flags.req_zero   = (req_ff.request_bytes == '0);
      flags.at_end     = !has_next;
      flags.fit        = (cur_len >= req_ff.request_bytes);
      flags.exact      = (cur_len == req_ff.request_bytes);
      flags.rm_last    = ((CW + 1)'(idx_ff) + (CW + 1)'(1)) >= (CW + 1)'(cnt_ff);
      flags.free_bad   = !in_heap || (size_ff == '0)
                         || (32'(free_end) > 32'(HEAP_BYTES));
      flags.scan_more  = has_next && (cur_start <= req_ff.block_address);
      flags.overlap    = (has_prev_ff && (prev_end_ff > addr_w))
                         || (has_next && (free_end > cur_start_w));
      flags.merge_prev = has_prev_ff && (prev_end_ff == addr_w);
      flags.merge_next = has_next && (free_end == cur_start_w);
      flags.full       = (32'(cnt_ff) >= 32'(MAX_RANGES));
      flags.ins_done   = (sh_ff == idx_ff);
   end

   // heap size written through the register port, saturated
   assign init_len = (32'(csr_data) > 32'(HEAP_BYTES)) ? 32'(HEAP_BYTES) : 32'(csr_data);

   // index of the entry in front of the scan pointer
   function automatic logic [IW-1:0] sh_fix(input logic [CW-1:0] p);
      logic [CW-1:0] q;
      q = p - CW'(1);
      return q[IW-1:0];
   endfunction

   // control registers and range table
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= CW'(1);
         idx_ff       <= '0;
         sh_ff        <= '0;
         has_prev_ff  <= 1'b0;
         grant_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         start_ff[0]  <= '0;
         len_ff[0]    <= LEN_W'(HEAP_BYTES);
      end else begin
         rsp_valid_ff <= 1'b0;
         case (cmd.op)
            DP_INIT: begin
               cnt_ff      <= (init_len != 32'd0) ? CW'(1) : CW'(0);
               start_ff[0] <= '0;
               len_ff[0]   <= LEN_W'(init_len);
            end
            DP_CAPTURE: begin
               req_ff      <= req_data;
               idx_ff      <= '0;
               has_prev_ff <= 1'b0;
               grant_ff    <= '0;
            end
            DP_SCAN_NEXT: begin
               idx_ff <= idx_p1;
            end
            DP_ALLOC_TAKE: begin
               grant_ff <= cur_start;
               if (cur_len != req_ff.request_bytes) begin
                  start_ff[rd_idx] <= cur_start + ADDR_W'(req_ff.request_bytes);
                  len_ff[rd_idx]   <= cur_len - req_ff.request_bytes;
               end
            end
            DP_REMOVE_STEP: begin
               start_ff[rd_idx] <= nxt_start;
               len_ff[rd_idx]   <= nxt_len;
               idx_ff           <= idx_p1;
            end
            DP_REMOVE_END: begin
               cnt_ff <= cnt_ff - CW'(1);
            end
            DP_FREE_STEP: begin
               prev_end_ff <= cur_start_w + EW'(cur_len);
               prev_len_ff <= cur_len;
               has_prev_ff <= 1'b1;
               idx_ff      <= idx_p1;
            end
            DP_MERGE_BOTH: begin
               len_ff[sh_fix(idx_ff)] <= prev_len_ff + size_ff + cur_len;
            end
            DP_MERGE_PREV: begin
               len_ff[sh_fix(idx_ff)] <= prev_len_ff + size_ff;
            end
            DP_MERGE_NEXT: begin
               start_ff[rd_idx] <= req_ff.block_address;
               len_ff[rd_idx]   <= cur_len + size_ff;
            end
            DP_INSERT_BEGIN: begin
               sh_ff <= cnt_ff;
            end
            DP_INSERT_STEP: begin
               start_ff[sh_ff[IW-1:0]] <= below_start;
               len_ff[sh_ff[IW-1:0]]   <= below_len;
               sh_ff                   <= sh_m1;
            end
            DP_INSERT_PUT: begin
               start_ff[rd_idx] <= req_ff.block_address;
               len_ff[rd_idx]   <= size_ff;
               cnt_ff           <= cnt_ff + CW'(1);
            end
            DP_RESPOND: begin
               rsp_valid_ff           <= 1'b1;
               rsp_ff.granted_address <= grant_ff;
               rsp_ff.status          <= cmd.rsp_status;
            end
            default: begin
            end
         endcase
      end
   end

   // granted size memory: written on allocation, read when a transaction is taken in
   always_ff @(posedge clock) begin
      if (cmd.op == DP_ALLOC_TAKE) begin
         gmem[HW'(cur_start)] <= req_ff.request_bytes;
      end
      if (cmd.op == DP_CAPTURE) begin
         size_ff <= gmem[HW'(req_data.block_address)];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // table never holds more ranges than it has room for
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= 32'(MAX_RANGES))
      else $error("range count above table size");

   // a result strobe lasts one cycle
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held two cycles");

   // the insert shift never walks below the insertion point
   a_insert_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_INSERT_STEP) |-> (sh_ff > idx_ff))
      else $error("insert shift passed insertion point");

endmodule
`default_nettype wire

>>> rtl/first_fit_range_allocator_top.sv
// top level of the first-fit range allocator
// depends on ffra_pkg, ffra_ctrl and ffra_dpath
`default_nettype none
// One transaction is taken while busy is low and start is high; its result
// shows on rsp_data for one cycle with rsp_valid high and cannot be held off.
// An allocate looks at the ranges in order until one fits, and moves the
// entries behind a range down when that range empties. A free first scans the
// ranges that start at or below the freed address, then moves entries up for
// an insert, or moves entries down when two ranges merge.
// busy drops in the cycle the result shows, so the next transaction can be
// taken at the edge that takes the result. The range table is scanned and
// shifted one entry a cycle. A csr write resets the table to one free range
// from zero of the written size, saturated at the heap size, or to an empty
// table when zero is written; recorded block sizes are kept.
module first_fit_range_allocator_top
   import ffra_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [LEN_W-1:0] csr_data
);

   dp_cmd_type   cmd;
   dp_flags_type flags;

   // controller
   ffra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_kind  (req_data.kind),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .busy      (busy),
      .flags     (flags),
      .cmd       (cmd)
   );

   // datapath
   ffra_dpath #(
      .MAX_RANGES (MAX_RANGES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_data  (csr_data),
      .flags     (flags),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

>>> dv/tb_first_fit_range_allocator_top.sv
// self-checking testbench of first_fit_range_allocator_top: directed and random
// allocate/free transactions plus heap size writes, checked against a local predictor
// depends on ffra_pkg and first_fit_range_allocator_top
`timescale 1ns / 100ps
module tb_first_fit_range_allocator_top;
   import ffra_pkg::*;

   localparam int HEAP  = HEAP_BYTES_DEF;
   localparam int SLOTS = MAX_RANGES_DEF;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [LEN_W-1:0] csr_data = '0;

   first_fit_range_allocator_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // predictor state: sorted free list and granted sizes
   logic [ADDR_W-1:0] free_start [SLOTS];
   logic [LEN_W-1:0]  free_len [SLOTS];
   int                free_count;
   logic [LEN_W-1:0]  block_size [HEAP];
   bit                block_known [HEAP];

   req_type pending_q [$];
   rsp_type expected_q [$];
   int      live_q [$];     // granted and not yet picked for a free
   int      known_q [$];    // every address with a recorded size

   int n_mismatch = 0;
   int n_alloc_ok = 0, n_nofit = 0, n_full = 0, n_frees = 0;
   int cfg_writes = 0;
   int idle_cycles = 0;
   bit acc_now = 1'b0;
   bit steady = 1'b0;
   int gap = 0;

   // append one transaction to the pending queue
   function automatic void enqueue(req_type r);
      pending_q = {pending_q, r};
   endfunction

   function automatic void heap_init(int value);
      int v;
      v = (value > HEAP) ? HEAP : value;
      for (int i = 0; i < SLOTS; i++) begin
         free_start[i] = '0;
         free_len[i] = '0;
      end
      free_count = (v == 0) ? 0 : 1;
      free_len[0] = LEN_W'(v);
   endfunction

   function automatic void drop_range(int p);
      for (int i = p; i + 1 < free_count; i++) begin
         free_start[i] = free_start[i+1];
         free_len[i] = free_len[i+1];
      end
      free_count--;
      free_start[free_count] = '0;
      free_len[free_count] = '0;
   endfunction

   function automatic status_type carve(int req, output int addr);
      int s;
      addr = 0;
      if (req == 0) return ST_NOFIT;
      for (int i = 0; i < free_count; i++) begin
         if (free_len[i] >= req) begin
            s = free_start[i];
            if (free_len[i] == req) drop_range(i);
            else begin
               free_start[i] = ADDR_W'(s + req);
               free_len[i] = LEN_W'(int'(free_len[i]) - req);
            end
            block_size[s] = LEN_W'(req);
            if (!block_known[s]) known_q = {known_q, s};
            block_known[s] = 1'b1;
            addr = s;
            return ST_OK;
         end
      end
      return ST_NOFIT;
   endfunction

   function automatic status_type give_back(int a);
      int sz, e, p, pe;
      bit mp, mn;
      mp = 0;
      mn = 0;
      sz = block_known[a] ? int'(block_size[a]) : 0;
      if (sz == 0) return ST_OK;
      e = a + sz;
      if (e > HEAP) return ST_OK;
      p = 0;
      while (p < free_count && free_start[p] <= a) p++;
      if (p > 0) begin
         pe = int'(free_start[p-1]) + int'(free_len[p-1]);
         if (pe > a) return ST_OK;
         mp = (pe == a);
      end
      if (p < free_count) begin
         if (e > free_start[p]) return ST_OK;
         mn = (e == free_start[p]);
      end
      if (mp && mn) begin
         free_len[p-1] = LEN_W'(int'(free_len[p-1]) + sz + int'(free_len[p]));
         drop_range(p);
      end else if (mp) begin
         free_len[p-1] = LEN_W'(int'(free_len[p-1]) + sz);
      end else if (mn) begin
         free_start[p] = ADDR_W'(a);
         free_len[p] = LEN_W'(int'(free_len[p]) + sz);
      end else begin
         if (free_count >= SLOTS) return ST_FULL;
         for (int i = free_count; i > p; i--) begin
            free_start[i] = free_start[i-1];
            free_len[i] = free_len[i-1];
         end
         free_start[p] = ADDR_W'(a);
         free_len[p] = LEN_W'(sz);
         free_count++;
      end
      return ST_OK;
   endfunction

   // acceptance, prediction, result check, csr tracking and watchdog
   always @(posedge clock) begin
      rsp_type want, got;
      int a;
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid) begin
            moved = 1'b1;
            got = rsp_data;
            if (expected_q.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("unexpected result addr=%0d status=%0d",
                           got.granted_address, got.status);
            end else begin
               want = expected_q.pop_front();
               if (got.granted_address !== want.granted_address ||
                   got.status !== want.status) begin
                  n_mismatch++;
                  if (n_mismatch <= 10)
                     $display("mismatch: expected addr=%0d status=%0d, %s%0d status=%0d",
                              want.granted_address, want.status, "got addr=",
                              got.granted_address, got.status);
               end
            end
         end
         if (start && !busy) begin
            moved = 1'b1;
            want = '0;
            if (req_data.kind == KIND_ALLOC) begin
               want.status = carve(int'(req_data.request_bytes), a);
               want.granted_address = ADDR_W'(a);
               if (want.status == ST_OK) begin
                  live_q = {live_q, a};
                  n_alloc_ok++;
               end else n_nofit++;
            end else begin
               want.status = give_back(int'(req_data.block_address));
               n_frees++;
               if (want.status == ST_FULL) n_full++;
            end
            expected_q = {expected_q, want};
         end
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            heap_init(int'(csr_data));
            cfg_writes++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
      end
      acc_now <= start && !busy && !reset;
   end

   // transaction driver with random idle bursts
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !acc_now) begin
         // hold the transaction until taken
      end else if (gap > 0) begin
         gap--;
         start <= 1'b0;
      end else if (pending_q.size() != 0) begin
         req_data <= pending_q.pop_front();
         start <= 1'b1;
         if (!steady && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
      end else begin
         start <= 1'b0;
      end
   end

   function automatic req_type alloc_item(int n);
      req_type r;
      r.kind = KIND_ALLOC;
      r.request_bytes = LEN_W'(n);
      r.block_address = ADDR_W'($urandom);
      return r;
   endfunction

   function automatic req_type free_item(int a);
      req_type r;
      r.kind = KIND_FREE;
      r.request_bytes = LEN_W'($urandom);
      r.block_address = ADDR_W'(a);
      return r;
   endfunction

   task automatic drain();
      while (pending_q.size() != 0 || start || expected_q.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_heap(int v);
      int seen;
      drain();
      seen = cfg_writes;
      csr_data <= LEN_W'(v);
      csr_valid <= 1'b1;
      while (cfg_writes == seen) @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random mix: mostly small allocations and frees of live blocks
   task automatic random_phase(int count);
      int k, sel, idx;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 45 || known_q.size() == 0) begin
            k = $urandom_range(0, 99);
            if (k < 70) enqueue(alloc_item($urandom_range(1, 32)));
            else if (k < 90) enqueue(alloc_item($urandom_range(33, 512)));
            else if (k < 97) enqueue(alloc_item($urandom_range(513, HEAP)));
            else if (k < 99) enqueue(alloc_item($urandom_range(HEAP + 1, 8191)));
            else enqueue(alloc_item(0));
         end else if (sel < 88 && live_q.size() != 0) begin
            idx = $urandom_range(0, live_q.size() - 1);
            enqueue(free_item(live_q[idx]));
            live_q.delete(idx);
         end else begin
            enqueue(free_item(known_q[$urandom_range(0, known_q.size() - 1)]));
         end
         // refill in small batches so frees only name recorded blocks
         if (n % 20 == 19) while (pending_q.size() != 0) @(negedge clock);
      end
   endtask

   initial begin
      for (int i = 0; i < HEAP; i++) begin
         block_size[i] = '0;
         block_known[i] = 1'b0;
      end
      heap_init(HEAP);
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // zero, oversized and whole-heap requests, then empty table and merges
      enqueue(alloc_item(0));
      enqueue(alloc_item(8191));
      enqueue(alloc_item(HEAP + 1));
      enqueue(alloc_item(100));
      enqueue(alloc_item(HEAP - 100));
      enqueue(alloc_item(1));
      enqueue(free_item(100));
      enqueue(alloc_item(1));
      enqueue(free_item(0));
      enqueue(free_item(0));
      enqueue(free_item(100));
      enqueue(alloc_item(HEAP));
      enqueue(free_item(0));
      drain();

      // heap of zero and of one byte
      write_heap(0);
      enqueue(alloc_item(5));
      enqueue(free_item(0));
      enqueue(free_item(0));
      write_heap(1);
      enqueue(alloc_item(1));
      enqueue(alloc_item(1));
      drain();

      // fragment a small heap until the range table overflows
      write_heap(33);
      for (int i = 0; i < 33; i++) enqueue(alloc_item(1));
      for (int i = 0; i <= 32; i += 2) enqueue(free_item(i));
      drain();

      live_q.delete();
      write_heap(HEAP);
      random_phase(120);
      drain();
      live_q.delete();
      write_heap(64);
      random_phase(120);
      drain();
      live_q.delete();
      write_heap(8191);
      random_phase(100);
      drain();
      live_q.delete();
      write_heap(1000);
      random_phase(60);
      steady = 1'b1;
      random_phase(100);
      drain();
      repeat (40) @(negedge clock);

      $display("covered %0d granted allocations, %0d failed allocations, %0d frees",
               n_alloc_ok, n_nofit, n_frees);
      $display("%0d frees hit a full range table, %0d heap size writes, %0d mismatches",
               n_full, cfg_writes, n_mismatch);
      if (n_mismatch == 0 && expected_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/ffra_pkg.sv
rtl/ffra_ctrl.sv
rtl/ffra_dpath.sv
rtl/first_fit_range_allocator_top.sv
dv/tb_first_fit_range_allocator_top.sv
